### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL; compiled to nothing under SYNTH.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

### sv/sfct_pkg.sv
// ---------------------------------------------------------------------------
// sfct_pkg
// Shared types, constants and the CRC-8 step for the sensor frame checker.
// ---------------------------------------------------------------------------
package sfct_pkg;

	// byte positions within a frame
	typedef enum logic [6:0] {
		PosTempHi  = 7'b000_0001,
		PosTempLo  = 7'b000_0010,
		PosTempCrc = 7'b000_0100,
		PosHumHi   = 7'b000_1000,
		PosHumLo   = 7'b001_0000,
		PosHumCrc  = 7'b010_0000,
		PosIdle    = 7'b100_0000
	} pos_t;

	localparam logic [7:0] CrcSeed = 8'hFF;
	localparam logic [7:0] CrcPoly = 8'h31;

	localparam int ProdW = 27;

	localparam logic [10:0]      TempScale  = 11'd1750;
	localparam logic [15:0]      TempRound  = 16'd32767;
	localparam logic [16:0]      TempDiv    = 17'd65535;
	localparam logic [11:0]      TempOffset = 12'd450;
	localparam logic signed [11:0] TempMin  = -12'sd450;
	localparam logic signed [11:0] TempMax  = 12'sd1300;

	localparam logic StatusOk     = 1'b0;
	localparam logic StatusCrcErr = 1'b1;

	// checked frame handed to the conversion stage
	typedef struct packed {
		logic             bad;
		logic [ProdW-1:0] prod;   // 1750*raw + 32767
	} frame_t;

	// one byte of CRC-8, MSB first, no final xor
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] v;
		v = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ((v << 1) ^ CrcPoly) : (v << 1);
		end
		return v;
	endfunction

endpackage

### sv/sfct_frame_check.sv
// ---------------------------------------------------------------------------
// sfct_frame_check
// Byte position tracking, CRC-8 check of both words, and the scaled
// temperature product, registered once per completed frame.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfct_frame_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	input  logic                frame_start,
	output logic                frame_valid,
	input  logic                frame_ready,
	output sfct_pkg::frame_t    frame
);

	sfct_pkg::pos_t   pos_q;
	logic [7:0]       crc_q;
	logic [7:0]       hi_q;
	logic [7:0]       lo_q;
	logic             fail_q;

	logic             frame_v_s1;
	sfct_pkg::frame_t frame_s1;

	logic             in_fire;
	logic             active;
	sfct_pkg::pos_t   pos_eff;
	logic [7:0]       crc_eff;
	logic             fail_eff;
	logic [7:0]       crc_upd;
	logic             crc_bad;
	logic             emit;
	sfct_pkg::frame_t frame_d;

	assign in_ready = !frame_v_s1 || frame_ready;
	assign in_fire  = in_valid && in_ready;

	// a start byte restarts the frame whatever the position
	always_comb begin
		if (frame_start) begin
			pos_eff = sfct_pkg::PosTempHi;
		end else begin
			pos_eff = pos_q;
		end
	end

	assign crc_eff  = frame_start ? sfct_pkg::CrcSeed : crc_q;
	assign fail_eff = frame_start ? 1'b0 : fail_q;
	assign active   = frame_start || (pos_q != sfct_pkg::PosIdle);
	assign crc_upd  = sfct_pkg::crc8_byte(crc_eff, rx_byte);
	assign crc_bad  = (crc_eff != rx_byte);
	assign emit     = in_fire && active && (pos_eff == sfct_pkg::PosHumCrc);

	always_comb begin
		frame_d.bad  = fail_eff || crc_bad;
		frame_d.prod = sfct_pkg::ProdW'({hi_q, lo_q}) * sfct_pkg::ProdW'(sfct_pkg::TempScale)
			+ sfct_pkg::ProdW'(sfct_pkg::TempRound);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= sfct_pkg::PosIdle;
			crc_q  <= sfct_pkg::CrcSeed;
			hi_q   <= '0;
			lo_q   <= '0;
			fail_q <= 1'b0;
		end else if (in_fire && active) begin
			case (pos_eff)
				sfct_pkg::PosTempHi: begin
					hi_q   <= rx_byte;
					crc_q  <= crc_upd;
					fail_q <= fail_eff;
					pos_q  <= sfct_pkg::PosTempLo;
				end
				sfct_pkg::PosTempLo: begin
					lo_q  <= rx_byte;
					crc_q <= crc_upd;
					pos_q <= sfct_pkg::PosTempCrc;
				end
				sfct_pkg::PosTempCrc: begin
					fail_q <= fail_eff || crc_bad;
					crc_q  <= sfct_pkg::CrcSeed;
					pos_q  <= sfct_pkg::PosHumHi;
				end
				sfct_pkg::PosHumHi: begin
					crc_q <= crc_upd;
					pos_q <= sfct_pkg::PosHumLo;
				end
				sfct_pkg::PosHumLo: begin
					crc_q <= crc_upd;
					pos_q <= sfct_pkg::PosHumCrc;
				end
				default: begin
					crc_q <= sfct_pkg::CrcSeed;
					pos_q <= sfct_pkg::PosIdle;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_v_s1 <= 1'b0;
		end else if (emit) begin
			frame_v_s1 <= 1'b1;
		end else if (frame_ready) begin
			frame_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			frame_s1 <= frame_d;
		end
	end

	assign frame_valid = frame_v_s1;
	assign frame       = frame_s1;

	`ASSERT_PROP(a_frame_hold, clk, arst_n,
		frame_v_s1 && !frame_ready |=> frame_v_s1 && $stable(frame_s1),
		"checked frame changed while stalled")
	`ASSERT_PROP(a_idle_ignores, clk, arst_n,
		in_fire && !frame_start && pos_q == sfct_pkg::PosIdle
			|=> pos_q == sfct_pkg::PosIdle && $stable(crc_q),
		"byte outside a frame changed state")
	`ASSERT_NEVER(a_pos_onehot, clk, arst_n, !$onehot(pos_q), "byte position not one-hot")

endmodule

### sv/sfct_temp_conv.sv
// ---------------------------------------------------------------------------
// sfct_temp_conv
// Divides the scaled product by 65535, removes the offset, and holds the
// result, or zero with a CRC error status for a bad frame, in the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfct_temp_conv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_valid,
	output logic                frame_ready,
	input  sfct_pkg::frame_t    frame,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [11:0]  temp_tenths,
	output logic                status
);

	logic               out_v_q;
	logic signed [11:0] temp_q;
	logic               status_q;

	logic [10:0]        quo_hi;
	logic [15:0]        quo_lo;
	logic [16:0]        fold;
	logic [10:0]        quo;
	logic [11:0]        temp_d;

	assign frame_ready = !out_v_q || out_ready;

	// x = a*65536 + b = a*65535 + (a + b), and a + b < 2*65535
	assign quo_hi = frame.prod[26:16];
	assign quo_lo = frame.prod[15:0];
	assign fold   = {6'd0, quo_hi} + {1'b0, quo_lo};
	assign quo    = quo_hi + 11'(fold >= sfct_pkg::TempDiv);
	assign temp_d = {1'b0, quo} - sfct_pkg::TempOffset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (frame_ready) begin
			out_v_q <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && frame_ready) begin
			temp_q   <= frame.bad ? 12'sd0 : $signed(temp_d);
			status_q <= frame.bad ? sfct_pkg::StatusCrcErr : sfct_pkg::StatusOk;
		end
	end

	assign out_valid   = out_v_q;
	assign temp_tenths = temp_q;
	assign status      = status_q;

	`ASSERT_PROP(a_err_zero, clk, arst_n,
		out_v_q && status_q == sfct_pkg::StatusCrcErr |-> temp_q == 12'sd0,
		"CRC error result carries a nonzero temperature")
	`ASSERT_PROP(a_temp_range, clk, arst_n,
		out_v_q && status_q == sfct_pkg::StatusOk
			|-> temp_q >= sfct_pkg::TempMin && temp_q <= sfct_pkg::TempMax,
		"temperature out of range")
	`ASSERT_PROP(a_take_new, clk, arst_n,
		frame_valid && frame_ready |=> out_v_q,
		"accepted frame did not reach the output register")

endmodule

### sv/sensor_frame_crc_temp_convert.sv
// ---------------------------------------------------------------------------
// sensor_frame_crc_temp_convert
// Sensor frame CRC-8 check and temperature conversion.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one frame byte per item:
//   temp high, temp low, temp CRC, hum high, hum low, hum CRC. frame_start
//   marks the first byte and restarts any partial frame. Bytes after the
//   sixth are dropped until the next start.
//   Output channel (out_valid/out_ready) gives one item per complete frame:
//   temp_tenths in tenths of a degree C and status (1 = CRC mismatch, temp 0).
//   Throughput: one byte per cycle while in_ready is high. A frame passes the
//   checked-frame register, then the output register that drives out_valid;
//   the product is formed in the first, the divide by 65535 in the second.
//   A stalled receiver holds the result; bytes keep flowing while a second
//   frame can still be parked in the checked-frame register. in_ready drops
//   only when both registers hold a result and out_ready is low.
//   After reset the block waits for a start byte; CRC seed is 0xFF.
// ---------------------------------------------------------------------------
module sensor_frame_crc_temp_convert (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [11:0] temp_tenths,
	output logic               status
);

	logic             frame_valid;
	logic             frame_ready;
	sfct_pkg::frame_t frame;

	sfct_frame_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

	sfct_temp_conv u_conv (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.temp_tenths (temp_tenths),
		.status      (status)
	);

endmodule

### test/sensor_frame_crc_temp_convert_test.sv
// ---------------------------------------------------------------------------
// sensor_frame_crc_temp_convert_test
// Self-checking bench for the sensor frame CRC check and temperature
// conversion. A queue of frame bytes (directed corner frames, then random
// good, corrupted, truncated and stray bytes) feeds a clocked driver. The
// driver runs a cycle-free model of the frame checker on every taken byte.
// A clocked monitor compares each output item with the oldest predicted
// result. Both sides idle at random, and the receiver holds off once for a
// long stretch so that the block fills up and backpressures its input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_frame_crc_temp_convert_test;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} frame_byte_t;

	typedef struct packed {
		logic signed [11:0] temp;
		logic               status;
	} reading_t;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte     = 8'h00;
	logic               frame_start = 1'b0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic signed [11:0] temp_tenths;
	logic               status;

	frame_byte_t pending_bytes[$];
	reading_t    expected_readings[$];
	int          error_count = 0;

	// frame checker model state
	sfct_pkg::pos_t frm_pos  = sfct_pkg::PosIdle;
	logic [7:0]     frm_crc  = sfct_pkg::CrcSeed;
	logic [7:0]     frm_hi   = 8'h00;
	logic [7:0]     frm_lo   = 8'h00;
	logic           frm_fail = 1'b0;

	// sender / receiver pacing
	int          send_wait    = 0;
	logic        send_burst   = 1'b0;
	int          recv_wait    = 0;
	logic        recv_burst   = 1'b0;
	int          hold_cnt     = 0;
	logic        hold_done    = 1'b0;
	int          readings_seen = 0;
	reading_t    got_reading;

	sensor_frame_crc_temp_convert i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.temp_tenths (temp_tenths),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// bitwise CRC-8, MSB first
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ data[i];
			r = {r[6:0], 1'b0} ^ (fb ? sfct_pkg::CrcPoly : 8'h00);
		end
		return r;
	endfunction

	function automatic logic [7:0] word_crc(input logic [15:0] w);
		return crc8_update(crc8_update(sfct_pkg::CrcSeed, w[15:8]), w[7:0]);
	endfunction

	// one taken byte through the frame checker model
	task automatic check_frame_byte(input logic [7:0] b, input logic st);
		logic [15:0]  raw;
		int unsigned  q;
		int           t;
		logic         bad;
		reading_t     r;
		if (st) begin
			frm_pos  = sfct_pkg::PosTempHi;
			frm_crc  = sfct_pkg::CrcSeed;
			frm_fail = 1'b0;
		end else if (frm_pos == sfct_pkg::PosIdle) begin
			return;
		end
		case (frm_pos)
			sfct_pkg::PosTempHi: begin
				frm_hi  = b;
				frm_crc = crc8_update(frm_crc, b);
				frm_pos = sfct_pkg::PosTempLo;
			end
			sfct_pkg::PosTempLo: begin
				frm_lo  = b;
				frm_crc = crc8_update(frm_crc, b);
				frm_pos = sfct_pkg::PosTempCrc;
			end
			sfct_pkg::PosTempCrc: begin
				if (frm_crc != b)
					frm_fail = 1'b1;
				frm_crc = sfct_pkg::CrcSeed;
				frm_pos = sfct_pkg::PosHumHi;
			end
			sfct_pkg::PosHumHi: begin
				frm_crc = crc8_update(frm_crc, b);
				frm_pos = sfct_pkg::PosHumLo;
			end
			sfct_pkg::PosHumLo: begin
				frm_crc = crc8_update(frm_crc, b);
				frm_pos = sfct_pkg::PosHumCrc;
			end
			default: begin
				bad = frm_fail || (frm_crc != b);
				raw = {frm_hi, frm_lo};
				q   = (1750 * int'(raw) + 32767) / 65535;
				t   = int'(q) - 450;
				r.temp   = bad ? 12'sd0 : t[11:0];
				r.status = bad ? sfct_pkg::StatusCrcErr : sfct_pkg::StatusOk;
				expected_readings.push_back(r);
				frm_crc = sfct_pkg::CrcSeed;
				frm_pos = sfct_pkg::PosIdle;
			end
		endcase
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic st);
		frame_byte_t fb;
		fb.data  = b;
		fb.start = st;
		pending_bytes.push_back(fb);
	endtask

	// full frame; a nonzero flip corrupts that word's CRC byte
	task automatic queue_frame(input logic [15:0] temp_raw, input logic [15:0] hum_raw,
			input logic [7:0] temp_flip, input logic [7:0] hum_flip);
		queue_byte(temp_raw[15:8], 1'b1);
		queue_byte(temp_raw[7:0], 1'b0);
		queue_byte(word_crc(temp_raw) ^ temp_flip, 1'b0);
		queue_byte(hum_raw[15:8], 1'b0);
		queue_byte(hum_raw[7:0], 1'b0);
		queue_byte(word_crc(hum_raw) ^ hum_flip, 1'b0);
	endtask

	function automatic logic [7:0] rand_flip();
		return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
	endfunction

	function automatic logic [15:0] rand_temp_raw();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 3));
			1: return 16'($urandom_range(16'hFFFC, 16'hFFFF));
			default: return 16'($urandom);
		endcase
	endfunction

	// stimulus
	initial begin
		int n;
		// stray byte before any start
		queue_byte(8'hFF, 1'b0);
		// coldest and hottest readings
		queue_frame(16'h0000, 16'hFFFF, 8'h00, 8'h00);
		queue_frame(16'hFFFF, 16'h0000, 8'h00, 8'h00);
		// bad temperature CRC, then a byte after the sixth
		queue_frame(16'h6666, 16'h8000, 8'h01, 8'h00);
		queue_byte(8'h00, 1'b0);
		// restart in mid frame, then bad humidity CRC
		queue_byte(8'h12, 1'b1);
		queue_byte(8'h34, 1'b0);
		queue_frame(16'h8000, 16'h1234, 8'h00, 8'h80);

		while (pending_bytes.size() < 1225) begin
			case ($urandom_range(0, 9))
				0: begin
					// truncated frame
					n = $urandom_range(1, 5);
					queue_byte(8'($urandom), 1'b1);
					for (int i = 1; i < n; i++)
						queue_byte(8'($urandom), 1'b0);
				end
				1: begin
					// stray bytes, start bit random
					n = $urandom_range(1, 3);
					for (int i = 0; i < n; i++)
						queue_byte(8'($urandom), 1'($urandom));
				end
				default: queue_frame(rand_temp_raw(), 16'($urandom), rand_flip(), rand_flip());
			endcase
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				check_frame_byte(rx_byte, frame_start);
			if (!in_valid || in_ready) begin
				if (send_wait != 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					rx_byte     <= pending_bytes[0].data;
					frame_start <= pending_bytes[0].start;
					void'(pending_bytes.pop_front());
					in_valid    <= 1'b1;
					if ($urandom_range(0, 63) == 0)
						send_burst = ~send_burst;
					send_wait = send_burst ? 0 : $urandom_range(0, 10);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got_reading.temp   = temp_tenths;
				got_reading.status = status;
				readings_seen++;
				if (expected_readings.size() == 0) begin
					$error("unexpected item: temp_tenths %0d status %0d", temp_tenths, status);
					error_count++;
				end else begin
					if (got_reading.temp !== expected_readings[0].temp) begin
						$error("temp_tenths mismatch: expected %0d, actual %0d",
							expected_readings[0].temp, got_reading.temp);
						error_count++;
					end
					if (got_reading.status !== expected_readings[0].status) begin
						$error("status mismatch: expected %0d, actual %0d",
							expected_readings[0].status, got_reading.status);
						error_count++;
					end
					void'(expected_readings.pop_front());
				end
				if ($urandom_range(0, 31) == 0)
					recv_burst = ~recv_burst;
				recv_wait = recv_burst ? 0 : $urandom_range(0, 10);
			end
			if (hold_cnt != 0) begin
				out_ready <= 1'b0;
			end else if (recv_wait != 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// long hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (!hold_done && readings_seen >= 40) begin
			hold_done <= 1'b1;
			hold_cnt  <= 300;
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (pending_bytes.size() != 0 || in_valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("sensor_frame_crc_temp_convert_test: clean");
		else
			$display("sensor_frame_crc_temp_convert_test: errors");
		$finish;
	end

	initial begin
		#400000;
		$display("sensor_frame_crc_temp_convert_test: errors");
		$finish;
	end

endmodule
